### hdl/ffba_pkg.sv
// Shared constants, codes and types of the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int unsigned MaxBlocks   = 64;
  localparam int unsigned HeaderBytes = 24;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned ReqW   = 24;
  localparam int unsigned SizeW  = 25;
  localparam int unsigned CountW = $clog2(MaxBlocks + 1);
  localparam int unsigned IdxW   = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [AddrW-1:0] HeapBaseReset  = 32'h0010_0000;
  localparam logic [AddrW-1:0] HeapLimitReset = 32'h0110_0000;

  // Command codes
  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegHeapBase  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeapLimit = 1'b1;

  typedef enum logic [2:0] {
    StReused    = 3'd0,
    StNew       = 3'd1,
    StFreed     = 3'd2,
    StNull      = 3'd3,
    StNoHeap    = 3'd4,
    StTableFull = 3'd5,
    StUnknown   = 3'd6
  } status_e;

  typedef struct packed {
    logic             is_free;
    logic [SizeW-1:0] size;
    logic [AddrW-1:0] payload;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic             cmd;
    logic [ReqW-1:0]  size;
    logic [AddrW-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    status_e          status;
  } resp_t;

  typedef struct packed {
    logic             base_we;
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] limit;
  } cfg_t;

endpackage

### hdl/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ffba_core.sv
// Allocator sequencer: block table scan, append and free bookkeeping.
`timescale 1ns / 1ps
module ffba_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ffba_pkg::req_t  req_i,
  input  ffba_pkg::cfg_t  cfg_i,
  input  logic            out_free_i,
  output logic            idle_o,
  output logic            done_o,
  output ffba_pkg::resp_t resp_o
);

  localparam logic [1:0] SIdle   = 2'd0;
  localparam logic [1:0] SScan   = 2'd1;
  localparam logic [1:0] SAppend = 2'd2;
  localparam logic [1:0] SResp   = 2'd3;

  logic [1:0] state_q, state_d;
  logic [ffba_pkg::CountW-1:0] count_q, count_d;
  logic [ffba_pkg::CountW-1:0] iss_q, iss_d;
  logic [ffba_pkg::IdxW-1:0]   chk_q, chk_d;
  logic rv_q, rv_d;
  logic [ffba_pkg::AddrW-1:0] bp_q, bp_d;
  logic cmd_q, cmd_d;
  logic [ffba_pkg::AddrW-1:0] addr_q, addr_d;
  logic [ffba_pkg::SizeW-1:0] want_q, want_d;
  ffba_pkg::resp_t res_q, res_d;

  logic ram_we, ram_re;
  logic [ffba_pkg::IdxW-1:0] ram_waddr, ram_raddr;
  ffba_pkg::entry_t ram_wdata, rd;
  logic [ffba_pkg::EntryW-1:0] rd_raw;

  logic hit;
  logic [ffba_pkg::AddrW:0] end_addr;
  logic [ffba_pkg::AddrW-1:0] new_payload;

  ffba_ram #(
    .Width(ffba_pkg::EntryW),
    .Depth(ffba_pkg::MaxBlocks)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_raw)
  );

  assign rd = ffba_pkg::entry_t'(rd_raw);

  // Shared compare unit: one table entry per cycle
  always_comb begin
    if (cmd_q == ffba_pkg::CmdFree) begin
      hit = rv_q && (rd.payload == addr_q);
    end else begin
      hit = rv_q && rd.is_free && (rd.size >= want_q);
    end
  end

  assign end_addr = {1'b0, bp_q} + (ffba_pkg::AddrW+1)'(ffba_pkg::HeaderBytes)
                    + (ffba_pkg::AddrW+1)'(want_q);
  assign new_payload = bp_q + ffba_pkg::AddrW'(ffba_pkg::HeaderBytes);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    iss_d     = iss_q;
    chk_d     = chk_q;
    rv_d      = rv_q;
    bp_d      = bp_q;
    cmd_d     = cmd_q;
    addr_d    = addr_q;
    want_d    = want_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = chk_q;
    ram_wdata = rd;
    ram_re    = 1'b0;
    ram_raddr = iss_q[ffba_pkg::IdxW-1:0];
    done_o    = 1'b0;

    if (cfg_i.base_we && (count_q == '0)) begin
      bp_d = cfg_i.base;
    end

    case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_d  = req_i.cmd;
          addr_d = req_i.addr;
          want_d = ({1'b0, req_i.size} + ffba_pkg::SizeW'(7)) & ~ffba_pkg::SizeW'(7);
          iss_d  = '0;
          rv_d   = 1'b0;
          if ((req_i.cmd == ffba_pkg::CmdFree) ? (req_i.addr == '0) : (req_i.size == '0)) begin
            res_d   = '{addr: '0, status: ffba_pkg::StNull};
            state_d = SResp;
          end else begin
            state_d = SScan;
          end
        end
      end
      SScan: begin
        if (hit) begin
          ram_we    = 1'b1;
          ram_waddr = chk_q;
          ram_wdata = '{is_free: (cmd_q == ffba_pkg::CmdFree), size: rd.size,
                        payload: rd.payload};
          if (cmd_q == ffba_pkg::CmdFree) begin
            res_d = '{addr: '0, status: ffba_pkg::StFreed};
          end else begin
            res_d = '{addr: rd.payload, status: ffba_pkg::StReused};
          end
          state_d = SResp;
        end else if (!rv_q && (iss_q >= count_q)) begin
          if (cmd_q == ffba_pkg::CmdFree) begin
            res_d   = '{addr: '0, status: ffba_pkg::StUnknown};
            state_d = SResp;
          end else begin
            state_d = SAppend;
          end
        end else if (iss_q < count_q) begin
          ram_re = 1'b1;
          chk_d  = iss_q[ffba_pkg::IdxW-1:0];
          iss_d  = iss_q + ffba_pkg::CountW'(1);
          rv_d   = 1'b1;
        end else begin
          rv_d = 1'b0;
        end
      end
      SAppend: begin
        if (end_addr > {1'b0, cfg_i.limit}) begin
          res_d = '{addr: '0, status: ffba_pkg::StNoHeap};
        end else if (count_q == ffba_pkg::CountW'(ffba_pkg::MaxBlocks)) begin
          res_d = '{addr: '0, status: ffba_pkg::StTableFull};
        end else begin
          ram_we    = 1'b1;
          ram_waddr = count_q[ffba_pkg::IdxW-1:0];
          ram_wdata = '{is_free: 1'b0, size: want_q, payload: new_payload};
          count_d   = count_q + ffba_pkg::CountW'(1);
          bp_d      = end_addr[ffba_pkg::AddrW-1:0];
          res_d     = '{addr: new_payload, status: ffba_pkg::StNew};
        end
        state_d = SResp;
      end
      SResp: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      iss_q   <= '0;
      rv_q    <= 1'b0;
      bp_q    <= ffba_pkg::HeapBaseReset;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      iss_q   <= iss_d;
      rv_q    <= rv_d;
      bp_q    <= bp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q  <= chk_d;
    cmd_q  <= cmd_d;
    addr_q <= addr_d;
    want_q <= want_d;
    res_q  <= res_d;
  end

  assign idle_o = (state_q == SIdle);
  assign resp_o = res_q;

endmodule

### hdl/first_fit_block_allocator_top.sv
// Flow: a null request goes straight to the response state; otherwise the table is scanned
// from the first entry (the scan reads one table entry per cycle), and an allocation that
// finds no free fit appends a new block. One request at a time: s_axis_tready stays low
// until the result is loaded, so output stalls also hold back the next request word.
// Reset: asynchronous active low; empties the table, break pointer to 0x00100000,
// heap limit to 0x01100000. Table contents are not cleared.
`timescale 1ns / 1ps
module first_fit_block_allocator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [55:0]                   s_axis_tdata,  // request_size, release_address
  input  logic                          s_axis_tuser,  // cmd
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // result_address
  output logic [2:0]                    m_axis_tuser,  // status
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffba_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ffba_pkg::AddrW-1:0]    cfg_data_i
);

  logic [ffba_pkg::AddrW-1:0] limit_q;
  logic out_valid_q;
  ffba_pkg::resp_t out_q;
  ffba_pkg::req_t req;
  ffba_pkg::cfg_t cfg;
  ffba_pkg::resp_t resp;
  logic core_idle, core_done, out_free, cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ffba_pkg::HeapLimitReset;
    end else if (cfg_we && (cfg_index_i == ffba_pkg::RegHeapLimit)) begin
      limit_q <= cfg_data_i;
    end
  end

  assign cfg = '{base_we: cfg_we && (cfg_index_i == ffba_pkg::RegHeapBase),
                 base: cfg_data_i, limit: limit_q};

  assign req = '{cmd: s_axis_tuser, size: s_axis_tdata[23:0], addr: s_axis_tdata[55:24]};

  assign s_axis_tready = core_idle;
  assign out_free      = !out_valid_q || m_axis_tready;

  ffba_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (s_axis_tvalid && s_axis_tready),
    .req_i     (req),
    .cfg_i     (cfg),
    .out_free_i(out_free),
    .idle_o    (core_idle),
    .done_o    (core_done),
    .resp_o    (resp)
  );

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      out_q <= resp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.addr;
  assign m_axis_tuser  = out_q.status;

endmodule

### bench/tb_first_fit_block_allocator_top.sv
// Testbench: directed and random allocate/free traffic against a first-fit table predictor.
`timescale 1ns / 1ps
module tb_first_fit_block_allocator_top;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = ffba_pkg::MaxBlocks + 16;
  localparam int unsigned PhaseItems    = 400;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [55:0]                   s_axis_tdata  = '0;  // request_size, release_address
  logic                          s_axis_tuser  = 1'b0;  // cmd
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [31:0]                   m_axis_tdata;  // result_address
  logic [2:0]                    m_axis_tuser;  // status
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [ffba_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [ffba_pkg::AddrW-1:0]    cfg_data_i    = '0;

  first_fit_block_allocator_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predicted allocator state
  logic [ffba_pkg::SizeW-1:0] blk_size    [ffba_pkg::MaxBlocks];
  logic [ffba_pkg::AddrW-1:0] blk_payload [ffba_pkg::MaxBlocks];
  logic                       blk_free    [ffba_pkg::MaxBlocks];
  int unsigned                blk_count    = 0;
  logic [ffba_pkg::AddrW-1:0] brk_ptr      = ffba_pkg::HeapBaseReset;
  logic [ffba_pkg::AddrW-1:0] heap_base_q  = ffba_pkg::HeapBaseReset;
  logic [ffba_pkg::AddrW-1:0] heap_limit_q = ffba_pkg::HeapLimitReset;

  ffba_pkg::resp_t resp_q[$];
  ffba_pkg::resp_t head_resp;
  int unsigned     src_idle_pct   = 0;
  int unsigned     sink_stall_pct = 0;
  int unsigned     error_count    = 0;
  int unsigned     request_count  = 0;
  int unsigned     cfg_count      = 0;
  int unsigned     idle_cycles    = 0;
  int unsigned     status_seen [8];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic ffba_pkg::resp_t first_fit_response(
      input logic cmd, input logic [ffba_pkg::ReqW-1:0] size,
      input logic [ffba_pkg::AddrW-1:0] addr);
    ffba_pkg::resp_t              r;
    logic [ffba_pkg::SizeW-1:0]   want;
    logic [ffba_pkg::AddrW+1:0]   end_addr;
    bit                           done;
    r.addr = '0;
    r.status = ffba_pkg::StNull;
    done = 1'b0;
    if (cmd == ffba_pkg::CmdAlloc) begin
      if (size != '0) begin
        want = ({1'b0, size} + ffba_pkg::SizeW'(7)) & ~ffba_pkg::SizeW'(7);
        for (int i = 0; i < blk_count; i++) begin
          if (!done && blk_free[i] && blk_size[i] >= want) begin
            blk_free[i] = 1'b0;
            r.addr = blk_payload[i];
            r.status = ffba_pkg::StReused;
            done = 1'b1;
          end
        end
        if (!done) begin
          end_addr = {2'b00, brk_ptr} + (ffba_pkg::AddrW+2)'(ffba_pkg::HeaderBytes)
                     + (ffba_pkg::AddrW+2)'(want);
          if (end_addr > {2'b00, heap_limit_q}) begin
            r.status = ffba_pkg::StNoHeap;
          end else if (blk_count >= ffba_pkg::MaxBlocks) begin
            r.status = ffba_pkg::StTableFull;
          end else begin
            blk_size[blk_count] = want;
            blk_payload[blk_count] = brk_ptr + ffba_pkg::AddrW'(ffba_pkg::HeaderBytes);
            blk_free[blk_count] = 1'b0;
            r.addr = blk_payload[blk_count];
            r.status = ffba_pkg::StNew;
            blk_count++;
            brk_ptr = end_addr[ffba_pkg::AddrW-1:0];
          end
        end
      end
    end else if (addr != '0) begin
      r.status = ffba_pkg::StUnknown;
      for (int i = 0; i < blk_count; i++) begin
        if (!done && blk_payload[i] == addr) begin
          blk_free[i] = 1'b1;
          r.status = ffba_pkg::StFreed;
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [ffba_pkg::SizeW-1:0] largest_free_size();
    logic [ffba_pkg::SizeW-1:0] best;
    best = '0;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] > best) best = blk_size[i];
    end
    return best;
  endfunction

  task automatic send_request(input logic cmd, input logic [ffba_pkg::ReqW-1:0] size,
                              input logic [ffba_pkg::AddrW-1:0] addr);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {addr, size};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    resp_q.push_back(first_fit_response(cmd, size, addr));
    request_count++;
  endtask

  task automatic send_alloc(input logic [ffba_pkg::ReqW-1:0] size);
    send_request(ffba_pkg::CmdAlloc, size, ffba_pkg::AddrW'($urandom()));
  endtask

  task automatic send_free(input logic [ffba_pkg::AddrW-1:0] addr);
    send_request(ffba_pkg::CmdFree, ffba_pkg::ReqW'($urandom()), addr);
  endtask

  task automatic wait_responses();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (resp_q.size() != 0) @(posedge clk_i);
  endtask

  // only issued with nothing outstanding
  task automatic write_register(input logic [ffba_pkg::CfgIdxW-1:0] idx,
                                input logic [ffba_pkg::AddrW-1:0] value);
    wait_responses();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == ffba_pkg::RegHeapBase) begin
      heap_base_q = value;
      if (blk_count == 0) brk_ptr = value;
    end else begin
      heap_limit_q = value;
    end
    cfg_count++;
    @(posedge clk_i);
  endtask

  task automatic test_null_and_unknown();
    send_free('0);
    send_free(32'h0000_1234);
    send_alloc('0);
    wait_responses();
  endtask

  task automatic test_reset_limits();
    send_alloc(24'hFF_FFFF);
    wait_responses();
  endtask

  task automatic test_break_extremes();
    write_register(ffba_pkg::RegHeapBase, 32'hFFFF_FFFF);
    write_register(ffba_pkg::RegHeapLimit, 32'h0000_0000);
    send_alloc(24'd1);
    write_register(ffba_pkg::RegHeapLimit, 32'hFFFF_FFFF);
    send_alloc(24'hFF_FFFF);
    send_alloc(24'd8);
    write_register(ffba_pkg::RegHeapBase, 32'h0000_0000);
    send_alloc(24'd1);
    send_alloc(24'hFF_FFFF);
    wait_responses();
  endtask

  task automatic test_reuse_and_double_free();
    send_free(blk_payload[0]);
    send_free(blk_payload[0]);
    send_alloc(24'd8);
    send_alloc(24'd9);
    send_free(blk_payload[1]);
    send_alloc(24'h000800);
    send_free(blk_payload[1] + 32'd1);
    send_free(32'hFFFF_FFFF);
    wait_responses();
  endtask

  task automatic test_heap_boundary();
    write_register(ffba_pkg::RegHeapLimit,
                   brk_ptr + ffba_pkg::AddrW'(ffba_pkg::HeaderBytes) + 32'd8);
    send_alloc(24'd9);
    send_alloc(24'd8);
    send_alloc(24'd1);
    wait_responses();
  endtask

  task automatic test_base_after_blocks();
    write_register(ffba_pkg::RegHeapBase, ffba_pkg::HeapBaseReset);
    write_register(ffba_pkg::RegHeapLimit, 32'hFFFF_FFFF);
    send_alloc(24'd1);
    wait_responses();
  endtask

  task automatic test_table_full();
    write_register(ffba_pkg::RegHeapLimit, 32'hFFFF_FFFF);
    while (blk_count < ffba_pkg::MaxBlocks) begin
      if (largest_free_size() >= ffba_pkg::SizeW'(25'h100_0000)) send_alloc(24'hFF_FFFF);
      else send_alloc(ffba_pkg::ReqW'(largest_free_size()) + 24'd1);
    end
    while (largest_free_size() >= ffba_pkg::SizeW'(25'h100_0000)) send_alloc(24'hFF_FFFF);
    send_alloc(ffba_pkg::ReqW'(largest_free_size()) + 24'd1);
    // heap check wins over the full table
    write_register(ffba_pkg::RegHeapLimit, brk_ptr);
    send_alloc(ffba_pkg::ReqW'(largest_free_size()) + 24'd1);
    wait_responses();
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                     input logic [ffba_pkg::AddrW-1:0] limit);
    int unsigned                pick;
    int unsigned                size_pick;
    logic [ffba_pkg::ReqW-1:0]  size;
    logic [ffba_pkg::AddrW-1:0] known;
    write_register(ffba_pkg::RegHeapBase, ffba_pkg::AddrW'($urandom()));
    write_register(ffba_pkg::RegHeapLimit, limit);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    repeat (PhaseItems) begin
      pick = $urandom_range(99);
      known = (blk_count != 0) ? blk_payload[$urandom_range(blk_count - 1)]
                               : ffba_pkg::AddrW'($urandom());
      if (pick < 48) begin
        size_pick = $urandom_range(99);
        if (size_pick < 70) size = ffba_pkg::ReqW'($urandom_range(64, 1));
        else if (size_pick < 92) size = ffba_pkg::ReqW'($urandom_range(1024, 1));
        else if (size_pick < 98) size = ffba_pkg::ReqW'($urandom());
        else size = '0;
        send_alloc(size);
      end else if (pick < 88) begin
        send_free(known);
      end else if (pick < 94) begin
        send_free(ffba_pkg::AddrW'($urandom()));
      end else if (pick < 97) begin
        send_free('0);
      end else begin
        send_free(pick[0] ? known + 32'd4 : known - 32'd8);
      end
    end
    wait_responses();
    src_idle_pct = 0;
    sink_stall_pct = 0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      status_seen[m_axis_tuser]++;
      if (resp_q.size() == 0) begin
        error_count++;
        $display("%0t: response with none outstanding: addr %h status %0d",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        head_resp = resp_q.pop_front();
        if (m_axis_tdata !== head_resp.addr) begin
          error_count++;
          $display("%0t: result_address expected %h actual %h",
                   $time, head_resp.addr, m_axis_tdata);
        end
        if (m_axis_tuser !== head_resp.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d",
                   $time, head_resp.status, m_axis_tuser);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no word moved for %0d cycles, %0d responses outstanding",
               $time, idle_cycles, resp_q.size());
      $display("tb_first_fit_block_allocator_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_null_and_unknown();
    test_reset_limits();
    test_break_extremes();
    test_reuse_and_double_free();
    test_heap_boundary();
    test_base_after_blocks();
    test_random_traffic(0, 0, brk_ptr + ffba_pkg::AddrW'($urandom_range(32'h4000, 32'h400)));
    test_table_full();
    test_random_traffic(80, 0, 32'hFFFF_FFFF);
    test_random_traffic(0, 80, brk_ptr + 32'h800);
    test_random_traffic(30, 30, ffba_pkg::AddrW'($urandom()));
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d requests and %0d register writes over four idle mixes;",
             request_count, cfg_count);
    $display("%0d of %0d blocks in use at the end", blk_count, ffba_pkg::MaxBlocks);
    $display("Status mix: reused %0d new %0d freed %0d null %0d no-heap %0d full %0d unknown %0d",
             status_seen[ffba_pkg::StReused], status_seen[ffba_pkg::StNew],
             status_seen[ffba_pkg::StFreed], status_seen[ffba_pkg::StNull],
             status_seen[ffba_pkg::StNoHeap], status_seen[ffba_pkg::StTableFull],
             status_seen[ffba_pkg::StUnknown]);
    if (error_count == 0 && resp_q.size() == 0) begin
      $display("tb_first_fit_block_allocator_top: clean");
    end else begin
      $display("tb_first_fit_block_allocator_top: errors");
    end
    $finish;
  end

endmodule

### sim.f
hdl/ffba_pkg.sv
hdl/ffba_ram.sv
hdl/ffba_core.sv
hdl/first_fit_block_allocator_top.sv
bench/tb_first_fit_block_allocator_top.sv
